// ----- hdl/bbe_pkg.sv -----
package bbe_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int PIX_W     = 24;
   localparam int WIDTH_W   = 11;
   localparam int HEIGHT_W  = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd768;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // Rows 0..2 from top to bottom, columns 0..2 from left to right.
   typedef pixel_type [0:2][0:2] grid_type;

   typedef struct packed {
      logic [1:0] row_lo;
      logic [1:0] col_lo;
   } mean_sel_type;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } in_word_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       last_of_run;
      logic       frame_done;
   } out_word_type;

endpackage

// ----- hdl/bbe_ram.sv -----
module bbe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hdl/bbe_mean.sv -----
module bbe_mean (
   input  logic                 clock,
   input  logic                 load,
   input  bbe_pkg::grid_type    grid,
   input  bbe_pkg::mean_sel_type sel,
   output bbe_pkg::pixel_type   mean
);
   import bbe_pkg::*;

   localparam int SUM_W  = 12;
   localparam int NUM_W  = 13;
   localparam int RCP_W  = 20;
   localparam int PROD_W = NUM_W + RCP_W;

   logic [SUM_W-1:0] sum_red_ff, sum_green_ff, sum_blue_ff;
   logic [SUM_W-1:0] sum_red_in, sum_green_in, sum_blue_in;
   logic [3:0]       count_ff, count_in;

   // ceil(2^20 / (2*count)); exact floor division for every numerator below 2^13.
   function automatic logic [RCP_W-1:0] recip(input logic [3:0] count);
      logic [RCP_W-1:0] r;
      case (count)
         4'd1:    r = 20'd524288;
         4'd2:    r = 20'd262144;
         4'd3:    r = 20'd174763;
         4'd4:    r = 20'd131072;
         4'd6:    r = 20'd87382;
         4'd9:    r = 20'd58255;
         default: r = 20'd524288;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] divide(input logic [SUM_W-1:0] sum,
                                         input logic [3:0] count);
      logic [NUM_W-1:0]  num;
      logic [PROD_W-1:0] prod;
      num  = NUM_W'({sum, 1'b0}) + NUM_W'(count);
      prod = PROD_W'(num) * PROD_W'(recip(count));
      return prod[RCP_W+7:RCP_W];
   endfunction

   always_comb begin
      sum_red_in   = '0;
      sum_green_in = '0;
      sum_blue_in  = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((2'(r) >= sel.row_lo) && (2'(c) >= sel.col_lo)) begin
               sum_red_in   = sum_red_in   + SUM_W'(grid[r][c].red);
               sum_green_in = sum_green_in + SUM_W'(grid[r][c].green);
               sum_blue_in  = sum_blue_in  + SUM_W'(grid[r][c].blue);
            end
         end
      end
      count_in = 4'(2'd3 - sel.row_lo) * 4'(2'd3 - sel.col_lo);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_red_ff   <= sum_red_in;
         sum_green_ff <= sum_green_in;
         sum_blue_ff  <= sum_blue_in;
         count_ff     <= count_in;
      end
   end

   assign mean.red   = divide(sum_red_ff, count_ff);
   assign mean.green = divide(sum_green_ff, count_ff);
   assign mean.blue  = divide(sum_blue_ff, count_ff);

endmodule

// ----- hdl/box_blur_edge_shrunk.sv -----
// An accepted word is read from both line stores while the sequencer is in ST_READ,
// and its first result is offered on rsp after the ST_SUM and ST_DIV steps.
// Each word passes through ST_READ and then ST_SUM and ST_DIV once per result
// (0 to 4 results), and ST_DIV waits while the output register is stalled.
// The line store read and the sum-then-divide pass over the mean unit hold the block busy.
// Synchronous reset clears the sequencer, window, positions and sets 1024 x 768; the
// line stores are not cleared and need no clearing pass.
module box_blur_edge_shrunk (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  bbe_pkg::in_word_type       req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bbe_pkg::out_word_type      rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [bbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bbe_pkg::CSR_DAT_W-1:0] csr_data
);
   import bbe_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SUM, ST_DIV} state_type;

   typedef struct packed {
      logic c_ge1;
      logic c_ge2;
      logic y_ge1;
      logic y_ge2;
      logic end_col;
      logic last_row;
   } pos_flags_type;

   state_type             state_ff;
   logic [WIDTH_W-1:0]    width_ff;
   logic [HEIGHT_W-1:0]   height_ff;
   logic [ADDR_W-1:0]     col_ff;
   logic [HEIGHT_W-1:0]   row_ff;
   logic [ADDR_W-1:0]     addr_ff;
   pos_flags_type         flags_ff;
   pixel_type             cur_ff;
   pixel_type [0:2][0:1]  win_ff;
   grid_type              grid_ff;
   logic [3:0]            mask_ff;
   logic                  rsp_valid_ff;
   out_word_type          rsp_data_ff;

   logic [ADDR_W-1:0]     w_last;
   logic [HEIGHT_W-1:0]   h_last;
   logic [ADDR_W-1:0]     col_eff;
   logic [HEIGHT_W-1:0]   row_eff;
   pos_flags_type         flags_in;
   logic                  req_accept;
   logic                  csr_accept;
   logic [PIX_W-1:0]      rd_older, rd_newer;
   grid_type              grid_in;
   logic [3:0]            mask_in;
   logic [1:0]            pick;
   logic [3:0]            mask_rest;
   mean_sel_type          sel;
   pixel_type             mean;
   logic                  out_free;

   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   // A register write takes priority over a new pixel word.
   assign req_stall  = (state_ff != ST_IDLE) || csr_valid;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // A width of zero counts as one, and widths beyond the line store saturate.
   always_comb begin
      if (width_ff == '0) begin
         w_last = '0;
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_last = ADDR_W'(MAX_WIDTH - 1);
      end else begin
         w_last = ADDR_W'(width_ff - WIDTH_W'(1));
      end
      h_last  = (height_ff == '0) ? '0 : height_ff - HEIGHT_W'(1);
      col_eff = (col_ff > w_last) ? w_last : col_ff;
      row_eff = (row_ff > h_last) ? h_last : row_ff;
      flags_in.c_ge1    = (col_eff >= ADDR_W'(1));
      flags_in.c_ge2    = (col_eff >= ADDR_W'(2));
      flags_in.y_ge1    = (row_eff >= HEIGHT_W'(1));
      flags_in.y_ge2    = (row_eff >= HEIGHT_W'(2));
      flags_in.end_col  = (col_eff == w_last);
      flags_in.last_row = (row_eff == h_last);
   end

   // Grid of the current word: two window columns, then the stores and the new pixel.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         grid_in[r][0] = win_ff[r][0];
         grid_in[r][1] = win_ff[r][1];
      end
      grid_in[0][2] = pixel_type'(rd_older);
      grid_in[1][2] = pixel_type'(rd_newer);
      grid_in[2][2] = cur_ff;
      // Order: left column then right column, each with the upper centre row first.
      mask_in[0] = flags_ff.c_ge1 && flags_ff.y_ge1;
      mask_in[1] = flags_ff.c_ge1 && flags_ff.last_row;
      mask_in[2] = flags_ff.end_col && flags_ff.y_ge1;
      mask_in[3] = flags_ff.end_col && flags_ff.last_row;
   end

   always_comb begin
      if (mask_ff[0]) begin
         pick = 2'd0;
      end else if (mask_ff[1]) begin
         pick = 2'd1;
      end else if (mask_ff[2]) begin
         pick = 2'd2;
      end else begin
         pick = 2'd3;
      end
      mask_rest = mask_ff & ~(4'd1 << pick);
      if (!pick[1]) begin
         sel.col_lo = flags_ff.c_ge2 ? 2'd0 : 2'd1;
      end else begin
         sel.col_lo = flags_ff.c_ge1 ? 2'd1 : 2'd2;
      end
      if (!pick[0]) begin
         sel.row_lo = flags_ff.y_ge2 ? 2'd0 : 2'd1;
      end else begin
         sel.row_lo = flags_ff.y_ge1 ? 2'd1 : 2'd2;
      end
   end

   bbe_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (addr_ff),
      .wr_data (rd_newer),
      .rd_addr (col_eff),
      .rd_data (rd_older)
   );

   bbe_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (addr_ff),
      .wr_data (PIX_W'(cur_ff)),
      .rd_addr (col_eff),
      .rd_data (rd_newer)
   );

   bbe_mean u_mean (
      .clock (clock),
      .load  (state_ff == ST_SUM),
      .grid  (grid_ff),
      .sel   (sel),
      .mean  (mean)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         win_ff       <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DIV)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  cur_ff   <= pixel_type'(req_data);
                  addr_ff  <= col_eff;
                  flags_ff <= flags_in;
                  if (col_eff == w_last) begin
                     col_ff <= '0;
                     row_ff <= (row_eff == h_last) ? '0 : row_eff + HEIGHT_W'(1);
                  end else begin
                     col_ff <= col_eff + ADDR_W'(1);
                     row_ff <= row_eff;
                  end
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               grid_ff <= grid_in;
               for (int r = 0; r < 3; r++) begin
                  win_ff[r][0] <= grid_in[r][1];
                  win_ff[r][1] <= grid_in[r][2];
               end
               mask_ff  <= mask_in;
               state_ff <= (mask_in != '0) ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (out_free) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.out_red     <= mean.red;
                  rsp_data_ff.out_green   <= mean.green;
                  rsp_data_ff.out_blue    <= mean.blue;
                  rsp_data_ff.last_of_run <= (mask_rest == '0);
                  rsp_data_ff.frame_done  <= (pick == 2'd3);
                  mask_ff                 <= mask_rest;
                  state_ff                <= (mask_rest != '0) ? ST_SUM : ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // Any register write restarts the frame; the line stores are kept.
         if (csr_accept) begin
            unique case (csr_index_type'(csr_index))
               REG_FRAME_WIDTH:  width_ff  <= WIDTH_W'(csr_data);
               REG_FRAME_HEIGHT: height_ff <= csr_data;
               default: begin
               end
            endcase
            col_ff <= '0;
            row_ff <= '0;
         end
      end
   end

   a_rsp_from_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DIV))
      else $error("result word appeared without a divide step");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.frame_done |-> rsp_data_ff.last_of_run)
      else $error("frame end flagged on a word that is not last of its run");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> mask_ff == '0)
      else $error("sequencer idle with results still pending");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> addr_ff <= w_last)
      else $error("line store address beyond the frame width");

endmodule
